@@ rtl/sobel_pkg.sv @@
package sobel_pkg;

  localparam int MaxWidthDefault = 2048;
  localparam int FrameWidthReset = 640;
  localparam int FrameHeightReset = 480;
  localparam int CfgDataWidth = 16;
  localparam logic CfgFrameWidth = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;
  localparam logic KindPixel = 1'b0;
  localparam logic KindFlush = 1'b1;

  // Squared magnitudes stay below 2 * 1020^2, so 21 bits are enough.
  localparam int SqWidth = 21;

  // One 3x3 neighborhood of a single 8-bit channel, row major.
  typedef logic [8:0][7:0] chan_win_t;

  // Work request handed to the square root unit.
  typedef struct packed {
    logic [2:0][SqWidth-1:0] sq;
    logic                    row_last;
    logic                    frame_last;
  } mag_req_t;

endpackage

@@ rtl/sobel_lane.sv @@
module sobel_lane (
  input  logic                         clk,
  input  logic                         load,
  input  sobel_pkg::chan_win_t         win,
  output logic [sobel_pkg::SqWidth-1:0] sq
);

  logic signed [11:0] gx;
  logic signed [11:0] gy;
  logic signed [11:0] gx_q;
  logic signed [11:0] gy_q;
  logic signed [21:0] gx_w;
  logic signed [21:0] gy_w;

  function automatic logic signed [11:0] px(input logic [7:0] v);
    px = $signed({4'd0, v});
  endfunction

  always_comb begin
    gx = px(win[2]) - px(win[0]) + 12'sd2 * (px(win[5]) - px(win[3]))
         + px(win[8]) - px(win[6]);
    gy = px(win[6]) + 12'sd2 * px(win[7]) + px(win[8])
         - px(win[0]) - 12'sd2 * px(win[1]) - px(win[2]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gx_q <= gx;
      gy_q <= gy;
    end
  end

  // Sign-extend before squaring so the products are formed at full width.
  assign gx_w = 22'(gx_q);
  assign gy_w = 22'(gy_q);
  assign sq = sobel_pkg::SqWidth'(gx_w * gx_w + gy_w * gy_w);

endmodule

@@ rtl/sobel_sqrt.sv @@
module sobel_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sobel_pkg::SqWidth-1:0] s,
  output logic                         busy,
  output logic                         done,
  output logic [7:0]                   mag
);

  typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;
  state_t state;
  logic [23:0] rem;
  logic [23:0] root;
  logic [23:0] bit_q;
  logic [23:0] trial;

  assign trial = root + bit_q;
  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == FIN);
      unique case (state)
        IDLE: begin
          if (start) begin
            rem <= 24'(s);
            root <= '0;
            bit_q <= 24'h400000;
            state <= RUN;
          end
        end
        RUN: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            root <= (root >> 1) + bit_q;
          end else begin
            root <= root >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 24'd1) state <= FIN;
        end
        FIN: begin
          if (rem > root) root <= root + 24'd1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // s > root^2 + root is rem > root after the digit loop.
  assign mag = (root > 24'd255) ? 8'd255 : root[7:0];

endmodule

@@ rtl/sobel_edge_rgb.sv @@
// Streaming 3x3 Sobel edge magnitude on RGB pixels.
// Input channel: valid/ready requests carrying kind and one RGB pixel. A
// pixel request (kind 0) is taken in raster order; after the frame's last
// pixel, flush requests (kind 1) drain the bottom row one result each.
// Requests that do not fit the current phase are accepted and dropped.
// Output channel: valid/ready requests with three magnitudes and row and
// frame markers. A pixel yields zero, one or two results.
// Each request is handled alone: a line store read (of three columns for a
// flush), a window step, a gradient step in three parallel channel lanes, a
// capture of their squares, then a shared bit-serial square root over the
// three lanes in turn. The square root sequencer sets the rate. A new
// request is taken only once the previous one has been handled.
// The output register holds a result while the receiver stalls; the block
// works on meanwhile and waits only when its next result is ready.
// Reset (rst, synchronous) restores width 640, height 480, clears the
// window and counters; the line stores are not cleared and need no pass.
// Configuration writes take effect at once and belong between frames.
module sobel_edge_rgb #(
  parameter int MAX_WIDTH = sobel_pkg::MaxWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        row_last,
  output logic        frame_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [sobel_pkg::CfgDataWidth-1:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WIN, S_GRAD, S_SQ, S_ROOT, S_OUT, S_NEXT
  } state_t;

  state_t state;
  logic [11:0] frame_width;
  logic [15:0] frame_height;
  logic [23:0] line_above [MAX_WIDTH];
  logic [23:0] line_two_above [MAX_WIDTH];
  logic [23:0] rd_a [3];
  logic [23:0] rd_b [3];
  logic [23:0] win [3][3];
  logic [23:0] p [3][3];
  logic [15:0] row_count;
  logic [CW-1:0] col_count;
  logic [CW-1:0] drain_col;
  logic draining;
  logic [23:0] px;
  logic is_flush;
  logic [1:0] rd_step;
  logic second;
  logic need_second;
  logic [1:0] lane_sel;
  logic [7:0] mags [3];
  logic cur_rl;
  logic cur_fl;
  logic [CW-1:0] w_eff;
  logic [15:0] h_m1;
  logic [CW-1:0] rd_col;
  logic lane_load;
  logic out_load;
  sobel_pkg::chan_win_t lw [3];
  logic [sobel_pkg::SqWidth-1:0] lsq [3];
  sobel_pkg::mag_req_t req;
  logic sq_start;
  logic sq_busy;
  logic sq_done;
  logic [7:0] sq_mag;

  // A drain neighbor column is usable when it lies inside the row.
  function automatic logic rd_ok_j(input int j);
    logic [CW-1:0] c;
    c = drain_col + CW'(j) - CW'(1);
    rd_ok_j = !(j == 0 && drain_col == '0) && (c < w_eff);
  endfunction

  always_comb begin
    if (frame_width == 12'd0) w_eff = CW'(1);
    else if (CW'(frame_width) > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(frame_width);
    h_m1 = (frame_height == 16'd0) ? 16'd0 : frame_height - 16'd1;
  end

  // Read address: pixel reads column col; drain reads d-1, d, d+1.
  always_comb begin
    if (!is_flush) begin
      rd_col = col_count;
    end else begin
      rd_col = drain_col + CW'(rd_step) - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 12'(sobel_pkg::FrameWidthReset);
      frame_height <= 16'(sobel_pkg::FrameHeightReset);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sobel_pkg::CfgFrameWidth: frame_width <= cfg_data[11:0];
        sobel_pkg::CfgFrameHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line stores: one read and one write port each, read data registered.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_a[rd_step] <= line_above[rd_col[AW-1:0]];
      rd_b[rd_step] <= line_two_above[rd_col[AW-1:0]];
    end
    if (state == S_WIN && !is_flush) begin
      line_two_above[col_count[AW-1:0]] <= rd_a[0];
      line_above[col_count[AW-1:0]] <= px;
    end
  end

  // Neighborhood for the current result, with out-of-frame zeros.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i][j] = win[i][j];
      end
    end
    if (!is_flush) begin
      if (second) begin
        for (int i = 0; i < 3; i++) begin
          p[i][0] = (col_count >= CW'(1)) ? win[i][1] : 24'd0;
          p[i][1] = win[i][2];
          p[i][2] = 24'd0;
        end
      end else if (col_count == CW'(1)) begin
        for (int i = 0; i < 3; i++) p[i][0] = 24'd0;
      end
      if (row_count == 16'd1) begin
        for (int j = 0; j < 3; j++) p[0][j] = 24'd0;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        lw[ch][k] = p[k / 3][k % 3][23 - 8 * ch -: 8];
      end
    end
  end

  assign lane_load = (state == S_GRAD);

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sobel_lane u_lane (
      .clk  (clk),
      .load (lane_load),
      .win  (lw[g]),
      .sq   (lsq[g])
    );
  end

  sobel_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .s     (req.sq[lane_sel]),
    .busy  (sq_busy),
    .done  (sq_done),
    .mag   (sq_mag)
  );

  assign sq_start = (state == S_ROOT) && !sq_busy && !sq_done;
  assign in_ready = (state == S_IDLE);

  // A finished result moves to the output register once it is free or
  // being emptied in the same cycle.
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      red_out <= mags[0];
      green_out <= mags[1];
      blue_out <= mags[2];
      row_last <= req.row_last;
      frame_last <= req.frame_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_count <= '0;
      col_count <= '0;
      drain_col <= '0;
      draining <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            px <= {red_in, green_in, blue_in};
            is_flush <= (kind == sobel_pkg::KindFlush);
            rd_step <= 2'd0;
            second <= 1'b0;
            if ((kind == sobel_pkg::KindFlush) == draining) state <= S_READ;
          end
        end
        S_READ: begin
          if (!is_flush || rd_step == 2'd2) state <= S_WIN;
          else rd_step <= rd_step + 2'd1;
        end
        S_WIN: begin
          if (!is_flush) begin
            for (int i = 0; i < 3; i++) begin
              win[i][0] <= win[i][1];
              win[i][1] <= win[i][2];
            end
            win[0][2] <= rd_b[0];
            win[1][2] <= rd_a[0];
            win[2][2] <= px;
            need_second <= (row_count >= 16'd1) && (col_count >= w_eff - CW'(1));
            second <= !(row_count >= 16'd1 && col_count >= CW'(1));
            cur_rl <= (col_count - CW'(1) == w_eff - CW'(1));
            cur_fl <= 1'b0;
          end else begin
            for (int j = 0; j < 3; j++) begin
              win[0][j] <= (rd_ok_j(j) && row_count >= 16'd1) ? rd_b[j] : 24'd0;
              win[1][j] <= rd_ok_j(j) ? rd_a[j] : 24'd0;
              win[2][j] <= 24'd0;
            end
            need_second <= 1'b0;
            second <= 1'b0;
            cur_rl <= (drain_col >= w_eff - CW'(1));
            cur_fl <= (drain_col >= w_eff - CW'(1));
          end
          state <= S_GRAD;
        end
        S_GRAD: begin
          if (!is_flush && second && !need_second) begin
            state <= S_NEXT;
          end else begin
            if (!is_flush && second) cur_rl <= 1'b1;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          for (int ch = 0; ch < 3; ch++) req.sq[ch] <= lsq[ch];
          req.row_last <= cur_rl;
          req.frame_last <= cur_fl;
          lane_sel <= 2'd0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            mags[lane_sel] <= sq_mag;
            if (lane_sel == 2'd2) begin
              state <= S_OUT;
            end else begin
              lane_sel <= lane_sel + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (!is_flush && !second && need_second) begin
              second <= 1'b1;
              state <= S_GRAD;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (!is_flush) begin
            if (col_count >= w_eff - CW'(1)) begin
              col_count <= '0;
              if (row_count >= h_m1) begin
                draining <= 1'b1;
                drain_col <= '0;
              end else begin
                row_count <= row_count + 16'd1;
              end
            end else begin
              col_count <= col_count + CW'(1);
            end
          end else if (drain_col >= w_eff - CW'(1)) begin
            row_count <= '0;
            col_count <= '0;
            drain_col <= '0;
            draining <= 1'b0;
          end else begin
            drain_col <= drain_col + CW'(1);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out))
    else $error("result changed while stalled");
  a_busy_no_req: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready)
    else $error("request taken while busy");
  a_fl_rl: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> row_last)
    else $error("frame end without row end");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> col_count < CW'(MAX_WIDTH))
    else $error("column beyond line store");

endmodule
